// File: rtl/i8gemm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8gemm_pkg
// Shared constants and helpers for the int8 matrix-multiply-accumulate tile.
// ----------------------------------------------------------------------------
package i8gemm_pkg;

    localparam int BYTE_W        = 8;
    localparam int PANEL_WORDS   = 4;
    localparam int PANEL_W       = PANEL_WORDS * 64;
    localparam int PANEL_BYTES   = PANEL_W / BYTE_W;
    localparam int IN_W          = 2 * PANEL_W;
    localparam int ACC_W         = 32;
    localparam int MAX_EMIT      = 8;
    localparam int ROW_IDX_W     = 3;
    localparam int OUT_FIELDS_W  = ROW_IDX_W + MAX_EMIT * ACC_W;
    localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int DEF_TILE_ROWS      = 8;
    localparam int DEF_TILE_COLS      = 8;
    localparam int DEF_DEPTH_PER_STEP = 4;

    // Width of one step's dot product: a byte product plus the growth of the sum.
    function automatic int dot_w(input int depth);
        return 2 * BYTE_W + ((depth > 1) ? $clog2(depth) : 0);
    endfunction

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Signed byte at a flat position of a panel; positions past the end read as zero.
    function automatic logic signed [BYTE_W-1:0] panel_byte(
        input logic [PANEL_W-1:0] panel,
        input int                 pos
    );
        if (pos >= PANEL_BYTES) begin
            return '0;
        end
        return $signed(panel[pos*BYTE_W +: BYTE_W]);
    endfunction

endpackage

// File: rtl/i8gemm_dot_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8gemm_dot_lane
// One tile row: the dot products of its bytes with every column of the right
// panel for one depth step, registered.
// ----------------------------------------------------------------------------
module i8gemm_dot_lane #(
    parameter int TILE_COLS      = i8gemm_pkg::DEF_TILE_COLS,
    parameter int DEPTH_PER_STEP = i8gemm_pkg::DEF_DEPTH_PER_STEP,
    localparam int DotW          = i8gemm_pkg::dot_w(DEPTH_PER_STEP)
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic signed [i8gemm_pkg::BYTE_W-1:0]     i_left_row [DEPTH_PER_STEP],
    input  logic        [i8gemm_pkg::PANEL_W-1:0]    i_right_panel,
    output logic signed [DotW-1:0]                   o_dot [TILE_COLS]
);

    localparam int ProdW = 2 * i8gemm_pkg::BYTE_W;

    logic signed [i8gemm_pkg::BYTE_W-1:0] w_right [TILE_COLS][DEPTH_PER_STEP];
    logic signed [ProdW-1:0]              w_prod  [TILE_COLS][DEPTH_PER_STEP];
    logic signed [DotW-1:0]               n_dot   [TILE_COLS];
    logic signed [DotW-1:0]               r_dot   [TILE_COLS];

    always_comb begin
        for (int c = 0; c < TILE_COLS; c++) begin
            n_dot[c] = '0;
            for (int d = 0; d < DEPTH_PER_STEP; d++) begin
                w_right[c][d] = i8gemm_pkg::panel_byte(i_right_panel, c * DEPTH_PER_STEP + d);
                w_prod[c][d]  = ProdW'(i_left_row[d]) * ProdW'(w_right[c][d]);
                n_dot[c]      = n_dot[c] + DotW'(w_prod[c][d]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot <= n_dot;
        end
    end

    assign o_dot = r_dot;

endmodule

// File: rtl/i8gemm_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8gemm_drain
// Holds a finished tile and sends it out one row per request.
// ----------------------------------------------------------------------------
module i8gemm_drain #(
    parameter int TILE_ROWS = i8gemm_pkg::DEF_TILE_ROWS,
    parameter int TILE_COLS = i8gemm_pkg::DEF_TILE_COLS,
    localparam int EmitRows = i8gemm_pkg::min_int(TILE_ROWS, i8gemm_pkg::MAX_EMIT),
    localparam int EmitCols = i8gemm_pkg::min_int(TILE_COLS, i8gemm_pkg::MAX_EMIT)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [i8gemm_pkg::ACC_W-1:0]     i_tile [EmitRows][EmitCols],
    output logic                             o_busy,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // row_index [2:0], sum_col_0 .. sum_col_7 (32 bits each) from bit 3, zero padded
    output logic [i8gemm_pkg::OUT_W-1:0]     o_m_tdata,
    // last_row
    output logic                             o_m_tlast
);

    localparam int RowW = (EmitRows > 1) ? $clog2(EmitRows) : 1;
    localparam int AccW = i8gemm_pkg::ACC_W;

    logic                r_busy;
    logic [RowW-1:0]     r_row;
    logic [AccW-1:0]     r_tile [EmitRows][EmitCols];
    logic                w_last;

    assign w_last = (r_row == RowW'(EmitRows - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (r_busy && i_m_tready) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tile <= i_tile;
        end
    end

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[i8gemm_pkg::ROW_IDX_W-1:0] = i8gemm_pkg::ROW_IDX_W'(r_row);
        for (int c = 0; c < EmitCols; c++) begin
            o_m_tdata[i8gemm_pkg::ROW_IDX_W + c*AccW +: AccW] = r_tile[r_row][c];
        end
    end

    assign o_busy     = r_busy;
    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = w_last;

endmodule

// File: rtl/int8_gemm_tile_8x8_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_gemm_tile_8x8_accumulate
// int8 matrix-multiply-accumulate tile: one depth step per request, tile out
// one row per request after the step marked last.
// ----------------------------------------------------------------------------
// Throughput: one depth step per cycle unless a last step waits for the output
//   buffer; the row lanes and the accumulator array each take a step every such cycle.
// Output: a tile's first row is offered once its last step has left the product
//   stage into the output buffer; then one row per cycle while i_m_tready is high.
// A last step waits in the product stage while the previous tile is still being
//   sent, so tiles with no more steps than output rows run at the output rate.
// Synchronous active-low reset clears the accumulators and empties both stages.
// ----------------------------------------------------------------------------
module int8_gemm_tile_8x8_accumulate #(
    parameter int TILE_ROWS      = i8gemm_pkg::DEF_TILE_ROWS,
    parameter int TILE_COLS      = i8gemm_pkg::DEF_TILE_COLS,
    parameter int DEPTH_PER_STEP = i8gemm_pkg::DEF_DEPTH_PER_STEP
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // left_rows_0_1, left_rows_2_3, left_rows_4_5, left_rows_6_7,
    // right_cols_0_1, right_cols_2_3, right_cols_4_5, right_cols_6_7 (64 bits each)
    input  logic [i8gemm_pkg::IN_W-1:0]      i_s_tdata,
    // last_step
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // row_index [2:0], sum_col_0 .. sum_col_7 (32 bits each) from bit 3, zero padded
    output logic [i8gemm_pkg::OUT_W-1:0]     o_m_tdata,
    // last_row
    output logic                             o_m_tlast
);

    localparam int DotW     = i8gemm_pkg::dot_w(DEPTH_PER_STEP);
    localparam int AccW     = i8gemm_pkg::ACC_W;
    localparam int PanelW   = i8gemm_pkg::PANEL_W;
    localparam int EmitRows = i8gemm_pkg::min_int(TILE_ROWS, i8gemm_pkg::MAX_EMIT);
    localparam int EmitCols = i8gemm_pkg::min_int(TILE_COLS, i8gemm_pkg::MAX_EMIT);

    logic                                 w_s_fire;
    logic                                 w_acc_fire;
    logic                                 w_drain_busy;
    logic                                 r_s1_valid;
    logic                                 r_s1_last;
    logic signed [i8gemm_pkg::BYTE_W-1:0] w_left [TILE_ROWS][DEPTH_PER_STEP];
    logic signed [DotW-1:0]               w_dot  [TILE_ROWS][TILE_COLS];
    logic        [AccW-1:0]               r_acc  [TILE_ROWS][TILE_COLS];
    logic        [AccW-1:0]               n_acc  [TILE_ROWS][TILE_COLS];
    logic        [AccW-1:0]               w_tile [EmitRows][EmitCols];

    // A last step only moves on once the output buffer is free to take the tile.
    assign w_acc_fire = r_s1_valid && (!r_s1_last || !w_drain_busy);
    assign o_s_tready = !r_s1_valid || w_acc_fire;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
        for (genvar d = 0; d < DEPTH_PER_STEP; d++) begin : g_byte
            assign w_left[r][d] =
                i8gemm_pkg::panel_byte(i_s_tdata[PanelW-1:0], r * DEPTH_PER_STEP + d);
        end

        i8gemm_dot_lane #(
            .TILE_COLS      (TILE_COLS),
            .DEPTH_PER_STEP (DEPTH_PER_STEP)
        ) u_lane (
            .i_clk         (i_clk),
            .i_en          (w_s_fire),
            .i_left_row    (w_left[r]),
            .i_right_panel (i_s_tdata[2*PanelW-1:PanelW]),
            .o_dot         (w_dot[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
            r_s1_last  <= i_s_tlast;
        end
    end

    always_comb begin
        for (int r = 0; r < TILE_ROWS; r++) begin
            for (int c = 0; c < TILE_COLS; c++) begin
                n_acc[r][c] = r_acc[r][c] + AccW'(w_dot[r][c]);
            end
        end
        for (int r = 0; r < EmitRows; r++) begin
            for (int c = 0; c < EmitCols; c++) begin
                w_tile[r][c] = n_acc[r][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                for (int c = 0; c < TILE_COLS; c++) begin
                    r_acc[r][c] <= '0;
                end
            end
        end else if (w_acc_fire) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                for (int c = 0; c < TILE_COLS; c++) begin
                    r_acc[r][c] <= r_s1_last ? '0 : n_acc[r][c];
                end
            end
        end
    end

    i8gemm_drain #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_acc_fire && r_s1_last),
        .i_tile     (w_tile),
        .o_busy     (w_drain_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
